FILE: rtl/core/dad_pkg.sv
// Shared types, microcode codes and calendar tables for the date add unit.
`default_nettype none

package dad_pkg;

	// Datapath operations selected by the control word
	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_SAVE_A = 4'd2;
	localparam logic [3:0] OP_SUM1   = 4'd3;
	localparam logic [3:0] OP_SUM2   = 4'd4;
	localparam logic [3:0] OP_CLAMP  = 4'd5;
	localparam logic [3:0] OP_EST    = 4'd6;
	localparam logic [3:0] OP_YDEC   = 4'd7;
	localparam logic [3:0] OP_YINC   = 4'd8;
	localparam logic [3:0] OP_DOY    = 4'd9;
	localparam logic [3:0] OP_MWALK  = 4'd10;
	localparam logic [3:0] OP_OUT    = 4'd11;

	// Jump conditions
	localparam logic [2:0] C_NEVER    = 3'd0;
	localparam logic [2:0] C_ALWAYS   = 3'd1;
	localparam logic [2:0] C_IDLE     = 3'd2;
	localparam logic [2:0] C_DOWN     = 3'd3;
	localparam logic [2:0] C_UP       = 3'd4;
	localparam logic [2:0] C_MORE     = 3'd5;
	localparam logic [2:0] C_OUT_FREE = 3'd6;

	// Operand fed to the days-before-year unit
	localparam logic [1:0] DBY_NONE = 2'd0;
	localparam logic [1:0] DBY_IN   = 2'd1;
	localparam logic [1:0] DBY_Y    = 2'd2;
	localparam logic [1:0] DBY_Y1   = 2'd3;

	// Program steps
	localparam logic [3:0] PC_IDLE  = 4'd0;
	localparam logic [3:0] PC_DOWN  = 4'd6;
	localparam logic [3:0] PC_UP    = 4'd8;
	localparam logic [3:0] PC_MWALK = 4'd12;
	localparam logic [3:0] PC_OUT   = 4'd13;

	// ceil(y/100) as (y+99) * M >> K, exact over the supported years
	localparam int DIV100_M     = 167773;
	localparam int DIV100_SHIFT = 24;
	// first guess of the year from a day number: n * 2^24 / 365.2425
	localparam int YEAR_RECIP   = 45934;
	localparam int RECIP_SHIFT  = 24;
	localparam int DAYS_LEAP    = 366;

	typedef struct packed {
		logic [1:0] dby_sel;
		logic [3:0] op;
		logic [2:0] cond;
		logic [3:0] target;
	} dad_ucw_t;

	typedef struct packed {
		logic down;
		logic up;
		logic more;
		logic out_free;
	} dad_stat_t;

	// Days before the first of a month, index 0 is January, common year
	function automatic logic [8:0] month_start(input logic [3:0] idx);
		logic [8:0] r;
		case (idx)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			default: r = 9'd334;
		endcase
		return r;
	endfunction

	// Month length, common year
	function automatic logic [4:0] month_len(input logic [3:0] idx);
		logic [4:0] r;
		case (idx)
			4'd1:                  r = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
			default:               r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dad_ucode_rom.sv
// Microcode program of the date add sequencer.
`default_nettype none

module dad_ucode_rom (
	input  wire logic [3:0]       pc,
	output dad_pkg::dad_ucw_t     word
);
	import dad_pkg::*;

	// {dby_sel, op, cond, target}
	always_comb begin
		unique case (pc)
			4'd0:  word = '{DBY_IN,   OP_LOAD,   C_IDLE,     PC_IDLE};
			4'd1:  word = '{DBY_Y1,   OP_SAVE_A, C_NEVER,    PC_IDLE};
			4'd2:  word = '{DBY_NONE, OP_SUM1,   C_NEVER,    PC_IDLE};
			4'd3:  word = '{DBY_NONE, OP_SUM2,   C_NEVER,    PC_IDLE};
			4'd4:  word = '{DBY_NONE, OP_CLAMP,  C_NEVER,    PC_IDLE};
			4'd5:  word = '{DBY_NONE, OP_EST,    C_NEVER,    PC_IDLE};
			// walk the year guess down while it starts past n
			4'd6:  word = '{DBY_Y,    OP_NOP,    C_NEVER,    PC_IDLE};
			4'd7:  word = '{DBY_NONE, OP_YDEC,   C_DOWN,     PC_DOWN};
			// walk it up while the next year starts at or before n
			4'd8:  word = '{DBY_Y1,   OP_NOP,    C_NEVER,    PC_IDLE};
			4'd9:  word = '{DBY_NONE, OP_YINC,   C_UP,       PC_UP};
			4'd10: word = '{DBY_Y,    OP_NOP,    C_NEVER,    PC_IDLE};
			4'd11: word = '{DBY_NONE, OP_DOY,    C_NEVER,    PC_IDLE};
			4'd12: word = '{DBY_NONE, OP_MWALK,  C_MORE,     PC_MWALK};
			4'd13: word = '{DBY_NONE, OP_OUT,    C_OUT_FREE, PC_IDLE};
			4'd14: word = '{DBY_NONE, OP_NOP,    C_ALWAYS,   PC_OUT};
			default: word = '{DBY_NONE, OP_NOP,  C_ALWAYS,   PC_IDLE};
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/dad_dby_unit.sv
// Two-stage unit for the number of days in all years before a given year.
`default_nettype none

module dad_dby_unit #(
	parameter int YW = 15,
	parameter int DW = 24
) (
	input  wire logic          clk,
	input  wire logic          load,
	input  wire logic [YW-1:0] year,
	output logic [DW-1:0]      days
);
	import dad_pkg::*;

	localparam int PW = YW + 1 + 18;
	localparam int QW = PW - DIV100_SHIFT;

	logic [YW:0]     y99;
	logic [PW-1:0]   c100_prod;
	logic [YW+8:0]   y365_s1;
	logic [YW-1:0]   y4_s1;
	logic [QW-1:0]   c100_s1;
	logic [YW:0]     y3;
	logic [QW-1:0]   c400;

	// Stage 1: 365*y, ceil(y/4), ceil(y/100)
	assign y3        = {1'b0, year} + (YW+1)'(3);
	assign y99       = {1'b0, year} + (YW+1)'(99);
	assign c100_prod = PW'(y99) * PW'(DIV100_M);

	always_ff @(posedge clk) begin
		if (load) begin
			y365_s1 <= (YW+9)'(year) * (YW+9)'(365);
			y4_s1   <= {1'b0, y3[YW:2]};
			c100_s1 <= c100_prod[DIV100_SHIFT +: QW];
		end
	end

	// Stage 2: ceil(y/400) = ceil(ceil(y/100)/4), then the sum
	assign c400 = QW'((c100_s1 + QW'(3)) >> 2);
	assign days = DW'(y365_s1) + DW'(y4_s1) - DW'(c100_s1) + DW'(c400);

endmodule

`default_nettype wire

FILE: rtl/core/dad_datapath.sv
// Registers and arithmetic driven by the microcode control word.
`default_nettype none

module dad_datapath #(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dad_pkg::dad_ucw_t  word,
	input  wire logic               jump,
	output dad_pkg::dad_stat_t      stat,
	input  wire logic [3:0]         in_month,
	input  wire logic [4:0]         in_day,
	input  wire logic [13:0]        in_year,
	input  wire logic signed [22:0] offset_days,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              out_month,
	output logic [4:0]              out_day,
	output logic [13:0]             out_year,
	output logic [21:0]             day_count,
	output logic                    out_of_range
);
	import dad_pkg::*;

	localparam int YB = $clog2(MAX_YEAR + 2);
	localparam int YW = (YB > 15) ? YB : 15;
	localparam int DW = YW + 9;
	localparam int CW = DW + 2;
	localparam int LAST_DAY = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
		- (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400;

	logic [3:0]           m_q;
	logic [4:0]           d_q;
	logic signed [22:0]   off_q;
	logic [YW-1:0]        y_q;
	logic [DW-1:0]        a_q;
	logic [DW-1:0]        b_q;
	logic signed [CW-1:0] cnt_q;
	logic [DW-1:0]        n_q;
	logic                 leap_q;
	logic                 flag_q;
	logic [3:0]           mo_q;
	logic [8:0]           doy_q;
	logic                 out_valid_q;

	logic                 dby_load;
	logic [YW-1:0]        dby_arg;
	logic [DW-1:0]        dby_val;
	logic [3:0]           m_idx;
	logic [DW+15:0]       est_prod;
	logic [5:0]           mlen;
	logic                 out_free;

	// Operand select for the days-before-year unit
	always_comb begin
		case (word.dby_sel)
			DBY_IN:  dby_arg = YW'(in_year);
			DBY_Y:   dby_arg = y_q;
			DBY_Y1:  dby_arg = y_q + YW'(1);
			default: dby_arg = y_q;
		endcase
	end
	assign dby_load = (word.dby_sel != DBY_NONE);

	dad_dby_unit #(
		.YW (YW),
		.DW (DW)
	) u_dby (
		.clk  (clk),
		.load (dby_load),
		.year (dby_arg),
		.days (dby_val)
	);

	// Month clamped to 1..12, kept as index 0..11
	always_comb begin
		if (in_month == 4'd0)
			m_idx = 4'd0;
		else if (in_month > 4'd12)
			m_idx = 4'd11;
		else
			m_idx = in_month - 4'd1;
	end

	assign est_prod = (DW+16)'(n_q) * (DW+16)'(YEAR_RECIP);
	assign mlen     = {1'b0, month_len(mo_q)} + 6'((mo_q == 4'd1) && leap_q);
	assign out_free = !out_valid_q || out_ready;

	// Status seen by the sequencer
	assign stat.down     = (dby_val > n_q) && (y_q != '0);
	assign stat.up       = (dby_val <= n_q);
	assign stat.more     = (9'(mlen) <= doy_q) && (mo_q != 4'd11);
	assign stat.out_free = out_free;

	// Payload registers
	always_ff @(posedge clk) begin
		case (word.op)
			OP_LOAD: begin
				if (!jump) begin
					m_q    <= m_idx;
					d_q    <= in_day;
					off_q  <= offset_days;
					y_q    <= YW'(in_year);
					flag_q <= 1'b0;
				end
			end
			OP_SAVE_A: begin
				a_q <= dby_val;
			end
			OP_SUM1: begin
				leap_q <= ((dby_val - a_q) == DW'(DAYS_LEAP));
				cnt_q  <= CW'(a_q) + CW'(month_start(m_q)) + CW'(d_q);
			end
			OP_SUM2: begin
				cnt_q <= cnt_q + CW'(off_q) + CW'((m_q > 4'd1) && leap_q);
			end
			OP_CLAMP: begin
				if (cnt_q < CW'(1)) begin
					cnt_q  <= CW'(1);
					n_q    <= '0;
					flag_q <= 1'b1;
				end else if (cnt_q > CW'(LAST_DAY)) begin
					cnt_q  <= CW'(LAST_DAY);
					n_q    <= DW'(LAST_DAY - 1);
					flag_q <= 1'b1;
				end else begin
					n_q <= DW'(cnt_q - CW'(1));
				end
			end
			OP_EST: begin
				y_q <= est_prod[RECIP_SHIFT +: YW];
			end
			OP_YDEC: begin
				if (jump)
					y_q <= y_q - YW'(1);
			end
			OP_YINC: begin
				b_q <= dby_val;
				if (jump)
					y_q <= y_q + YW'(1);
			end
			OP_DOY: begin
				leap_q <= ((b_q - dby_val) == DW'(DAYS_LEAP));
				doy_q  <= 9'(n_q - dby_val);
				mo_q   <= 4'd0;
			end
			OP_MWALK: begin
				if (jump) begin
					doy_q <= doy_q - 9'(mlen);
					mo_q  <= mo_q + 4'd1;
				end
			end
			OP_OUT: begin
				if (jump) begin
					out_month    <= mo_q + 4'd1;
					out_day      <= 5'(doy_q + 9'd1);
					out_year     <= y_q[13:0];
					day_count    <= cnt_q[21:0];
					out_of_range <= flag_q;
				end
			end
			default: ;
		endcase
	end

	// Output request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((word.op == OP_OUT) && jump) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/date_add_days_unit.sv
// Top level: microcoded Gregorian date plus signed day offset.
//
//  channel | signals                                         | dir
//  in      | in_valid in_ready in_month in_day in_year       | request in
//          | offset_days                                     |
//  out     | out_valid out_ready out_month out_day out_year  | request out
//          | day_count out_of_range                          |
//
// One request at a time; a request holds the unit from its acceptance to the next free
// input slot, longer for each year correction step (usually zero or one) and each month
// walked (up to 11). The result is registered by the output step, which follows those steps.
// The run time is set by the step counter running one control word per cycle and by
// the single days-before-year unit that the steps share.
// Reset clears the step counter and the output valid; no clearing pass.
// A stalled output keeps the sequencer cycling between its output step and the step
// that returns to it; a new request is taken while the previous result still waits
// downstream.
`default_nettype none

module date_add_days_unit #(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [3:0]         in_month,
	input  wire logic [4:0]         in_day,
	input  wire logic [13:0]        in_year,
	input  wire logic signed [22:0] offset_days,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              out_month,
	output logic [4:0]              out_day,
	output logic [13:0]             out_year,
	output logic [21:0]             day_count,
	output logic                    out_of_range
);
	import dad_pkg::*;

	logic [3:0] pc_q;
	dad_ucw_t   word;
	dad_stat_t  stat;
	logic       jump;

	dad_ucode_rom u_rom (
		.pc   (pc_q),
		.word (word)
	);

	// Jump condition
	always_comb begin
		case (word.cond)
			C_ALWAYS:   jump = 1'b1;
			C_IDLE:     jump = !in_valid;
			C_DOWN:     jump = stat.down;
			C_UP:       jump = stat.up;
			C_MORE:     jump = stat.more;
			C_OUT_FREE: jump = stat.out_free;
			default:    jump = 1'b0;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (jump) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

	assign in_ready = (pc_q == PC_IDLE);

	dad_datapath #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.word         (word),
		.jump         (jump),
		.stat         (stat),
		.in_month     (in_month),
		.in_day       (in_day),
		.in_year      (in_year),
		.offset_days  (offset_days),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_month    (out_month),
		.out_day      (out_day),
		.out_year     (out_year),
		.day_count    (day_count),
		.out_of_range (out_of_range)
	);

endmodule

`default_nettype wire

FILE: tb/sv/date_add_checker.sv
// Request/result monitor for the date add unit: predicts each date and compares the results.
`timescale 1ns / 100ps

module date_add_checker #(
	parameter int MAX_YEAR = 9999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic [13:0]        in_year,
	input  logic signed [22:0] offset_days,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [3:0]         out_month,
	input  logic [4:0]         out_day,
	input  logic [13:0]        out_year,
	input  logic [21:0]        day_count,
	input  logic               out_of_range,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
		logic [21:0] count;
		logic        clipped;
	} date_result_t;

	// Results still owed by the block, oldest first
	date_result_t expected_dates[$];

	function automatic bit leap_year(input longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// Whole days in years 0 .. y-1
	function automatic longint days_to_year(input longint y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// Month index 0 is January
	function automatic longint days_in_month(input int idx, input bit leap);
		case (idx)
			1:             return leap ? 29 : 28;
			3, 5, 8, 10:   return 30;
			default:       return 31;
		endcase
	endfunction

	// Date to day number, add the offset, saturate, and back to a date
	function automatic date_result_t shift_date(input logic [3:0] m, input logic [4:0] d,
			input logic [13:0] y, input logic signed [22:0] off);
		date_result_t r;
		longint mon, total, last, n, yr, doy;
		int mi;
		bit leap;
		mon = longint'(m);
		if (mon < 1) mon = 1;
		if (mon > 12) mon = 12;
		leap = leap_year(longint'(y));
		total = days_to_year(longint'(y)) + longint'(d);
		for (mi = 0; mi < mon - 1; mi++)
			total += days_in_month(mi, leap);
		total += longint'(off);
		last = days_to_year(longint'(MAX_YEAR) + 1);
		r.clipped = 1'b0;
		if (total < 1) begin
			total = 1;
			r.clipped = 1'b1;
		end
		if (total > last) begin
			total = last;
			r.clipped = 1'b1;
		end
		// year from a rough estimate, then nudged into place
		n = total - 1;
		yr = (n * 400) / 146097;
		while (yr > 0 && days_to_year(yr) > n) yr--;
		while (days_to_year(yr + 1) <= n) yr++;
		doy = n - days_to_year(yr);
		leap = leap_year(yr);
		mi = 0;
		while (mi < 11 && doy >= days_in_month(mi, leap)) begin
			doy -= days_in_month(mi, leap);
			mi++;
		end
		r.month = 4'(mi + 1);
		r.day   = 5'(doy + 1);
		r.year  = 14'(yr);
		r.count = 22'(total);
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Results are checked before the request of the same edge is queued
	always @(posedge clk or negedge arst_n) begin
		date_result_t want;
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
			expected_dates.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					$display("%0t ns: result with none expected, actual %0d-%0d-%0d", $time,
						out_year, out_month, out_day);
					fail_count++;
				end else begin
					want = expected_dates.pop_front();
					check_field("out_month", longint'(want.month), longint'(out_month));
					check_field("out_day", longint'(want.day), longint'(out_day));
					check_field("out_year", longint'(want.year), longint'(out_year));
					check_field("day_count", longint'(want.count), longint'(day_count));
					check_field("out_of_range", longint'(want.clipped),
						longint'(out_of_range));
				end
			end
			if (in_valid && in_ready)
				expected_dates.push_back(shift_date(in_month, in_day, in_year, offset_days));
			pending = expected_dates.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// Top of the date add unit testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_DATES = 380;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [3:0]         in_month = '0;
	logic [4:0]         in_day = '0;
	logic [13:0]        in_year = '0;
	logic signed [22:0] offset_days = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [3:0]         out_month;
	logic [4:0]         out_day;
	logic [13:0]        out_year;
	logic [21:0]        day_count;
	logic               out_of_range;

	int fail_count;
	int pending;
	int ready_hold = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	date_add_days_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_month     (in_month),
		.in_day       (in_day),
		.in_year      (in_year),
		.offset_days  (offset_days),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_month    (out_month),
		.out_day      (out_day),
		.out_year     (out_year),
		.day_count    (day_count),
		.out_of_range (out_of_range)
	);

	date_add_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_month     (in_month),
		.in_day       (in_day),
		.in_year      (in_year),
		.offset_days  (offset_days),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_month    (out_month),
		.out_day      (out_day),
		.out_year     (out_year),
		.day_count    (day_count),
		.out_of_range (out_of_range),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Result side stalls
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (no_idle || $urandom_range(0, 2) != 0) begin
			out_ready = 1'b1;
			ready_hold = $urandom_range(0, 6);
		end else begin
			out_ready = 1'b0;
			ready_hold = pick_gap();
		end
	end

	// Watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one request at a falling edge and hold it until taken
	task automatic send_date(input logic [3:0] m, input logic [4:0] d, input logic [13:0] y,
			input logic signed [22:0] off);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_month = m;
		in_day = d;
		in_year = y;
		offset_days = off;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly real dates, some near the span ends, the rest raw bits
	task automatic send_random_date();
		int r, k, v;
		logic [3:0] m;
		logic [4:0] d;
		logic [13:0] y;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			m = 4'($urandom_range(1, 12));
			d = 5'($urandom_range(1, ($urandom_range(0, 9) < 8) ? 28 : 31));
			if (r < 78)
				y = 14'($urandom_range(0, 9999));
			else
				y = $urandom_range(0, 1) ? 14'($urandom_range(9990, 9999))
					: 14'($urandom_range(0, 5));
		end else begin
			v = $urandom;
			m = v[3:0];
			d = v[8:4];
			y = v[22:9];
		end
		k = $urandom_range(0, 99);
		if (k < 30)
			v = int'($urandom_range(0, 800)) - 400;
		else if (k < 55)
			v = int'($urandom_range(0, 200000)) - 100000;
		else if (k < 85)
			v = int'($urandom_range(0, 7304850)) - 3652425;
		else
			v = $urandom;
		send_date(m, d, y, v[22:0]);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Span ends and saturation
		send_date(4'd1, 5'd1, 14'd0, 23'sd0);
		send_date(4'd1, 5'd1, 14'd0, -23'sd1);
		send_date(4'd1, 5'd0, 14'd0, 23'sd0);
		send_date(4'd12, 5'd31, 14'd9999, 23'sd0);
		send_date(4'd12, 5'd31, 14'd9999, 23'sd1);
		send_date(4'd1, 5'd1, 14'd0, 23'sd3652424);
		send_date(4'd12, 5'd31, 14'd9999, -23'sd3652424);
		send_date(4'd0, 5'd0, 14'd0, 23'sh3FFFFF);
		send_date(4'd15, 5'd31, 14'd16383, 23'sh400000);
		send_date(4'd15, 5'd31, 14'd16383, 23'sd0);
		send_date(4'd1, 5'd1, 14'd10000, -23'sd400);
		// Month clamping
		send_date(4'd0, 5'd15, 14'd2023, 23'sd0);
		send_date(4'd13, 5'd15, 14'd2023, 23'sd0);
		// Day zero and days past month end
		send_date(4'd3, 5'd0, 14'd2000, 23'sd0);
		send_date(4'd2, 5'd31, 14'd2001, 23'sd0);
		send_date(4'd4, 5'd31, 14'd2024, 23'sd0);
		// Leap rule: century, quad-century and ordinary leap years
		send_date(4'd2, 5'd28, 14'd1900, 23'sd1);
		send_date(4'd2, 5'd28, 14'd2000, 23'sd1);
		send_date(4'd12, 5'd31, 14'd2004, -23'sd1);
		send_date(4'd3, 5'd1, 14'd2100, -23'sd1);
		send_date(4'd12, 5'd31, 14'd1999, 23'sd1);
		send_date(4'd2, 5'd29, 14'd0, 23'sd366);

		// Random part in phases: normal, no idling, normal again
		for (int i = 0; i < RANDOM_DATES; i++) begin
			no_idle = (i >= 120 && i < 200);
			send_random_date();
		end
		no_idle = 1'b0;
		in_valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
